>>> sv/tmp_pkg.sv
// Shared types and constants for the trapezoid motion profile block.
// No dependencies; imported by every module of the block.
package tmp_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_RESET = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_BRAKE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  localparam logic [1:0] CFG_DISTANCE = 2'd0;
  localparam logic [1:0] CFG_PEAK     = 2'd1;
  localparam logic [1:0] CFG_END      = 2'd2;
  localparam logic [1:0] CFG_ACCEL    = 2'd3;

  localparam int unsigned DIV_W  = 49;
  localparam int unsigned DIVR_W = 32;

  localparam logic [31:0] FX_ONE    = 32'd65536;
  localparam logic [33:0] FX_EIGHTH = 34'd8192;
  localparam logic [31:0] US_PER_S  = 32'd1000000;
  // floor(2^47 / 1e6); applied to the top 32 bits of a 47-bit product
  localparam logic [27:0] US_RECIP  = 28'd140737488;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        tick_time_us;
    logic signed [31:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] command_speed;
    logic signed [31:0] travelled;
    logic [1:0]         phase;
    logic               done_res;
  } out_res_t;

  typedef struct packed {
    op_e                op;
    logic [15:0]        us;
    logic signed [31:0] fb;
  } q_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // magnitude with the most negative value pinned to the largest positive one
  function automatic logic [30:0] mag_sat(logic signed [31:0] v);
    logic [31:0] m;
    m = abs32(v);
    return m[31] ? 31'h7FFF_FFFF : m[30:0];
  endfunction

endpackage

>>> sv/trapezoid_motion_profile.sv
// Top level of the trapezoid motion profile: command queue plus sequencer.
// Depends on tmp_pkg, tmp_front, tmp_back (and tmp_div through tmp_back).
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  in       | in_valid_i/in_stall_o   | in_item_i  (in_item_t)
//  out      | out_valid_o/out_stall_i | out_res_o  (out_res_t)
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A tick steps through the sequencer states: speed step and position step each
// need a multiply and a reciprocal division by 1e6, then come the shared-multiplier
// braking-distance products. A full move with accel of at least 1.0 starts with a
// 49-step reciprocal division; stop, reset, short moves and idle ticks go straight
// to the result. The intake queue (QUEUE_DEPTH entries) keeps taking requests while
// the sequencer works or the output is stalled, and stalls input when full.
// Reset clears the configuration, the move state and all control state.
module trapezoid_motion_profile import tmp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_res_t    out_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic    q_valid, q_pop;
  q_item_t q_item;

  assign cfg_ready_o = 1'b1;

  tmp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_item_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  tmp_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .out_valid_o, .out_stall_i, .out_res_o
  );

endmodule

>>> sv/tmp_front.sv
// Command intake: accepts requests, decodes the opcode and buffers them.
// Depends on tmp_pkg.
module tmp_front import tmp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     q_valid_o,
  output q_item_t  q_item_o,
  input  logic     q_pop_i
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  q_item_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;
  q_item_t         dec;

  assign in_stall_o = (cnt_q == CW'(QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    dec.op = op_e'(in_item_i.op);
    dec.us = in_item_i.tick_time_us;
    dec.fb = in_item_i.measured_speed;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> sv/tmp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tmp_pkg for the request and response types.
module tmp_div import tmp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned NW = $clog2(DIV_W);

  logic              busy_q, done_q;
  logic [NW-1:0]     cnt_q;
  logic [DIVR_W:0]   rem_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DIVR_W-1:0] dvs_q;
  logic [DIVR_W:0]   rem_sh, dvs_x;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q[DIVR_W-1:0], quo_q[DIV_W-1]};
    dvs_x  = {1'b0, dvs_q};
    ge     = (rem_sh >= dvs_x);
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == NW'(DIV_W - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sh - dvs_x : rem_sh;
        quo_q <= {quo_q[DIV_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == NW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

>>> sv/tmp_back.sv
// Profile sequencer: executes queued commands with a shared multiplier and
// divider, holds the move state and the configuration. Depends on tmp_pkg, tmp_div.
module tmp_back import tmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  q_item_t     q_item_i,
  output logic        q_pop_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_res_t    out_res_o
);

  typedef enum logic [4:0] {
    S_FETCH, S_DV_MUL, S_DV_EST, S_DV_BACK, S_DV_FIX,
    S_POS_MUL, S_POS_EST, S_POS_BACK, S_POS_FIX,
    S_SA, S_SB, S_DIFF, S_LO, S_HI, S_BRK, S_UPD, S_RCP_WAIT, S_EMIT
  } state_e;

  state_e state_q;

  logic signed [31:0] cfg_dist_q, cfg_peak_q, cfg_end_q;
  logic [30:0]        cfg_accel_q;

  logic signed [31:0] pos_q, spd_q, goal_q, fin_q;
  logic [30:0]        goal_dist_q, accel_q;
  logic [32:0]        recip_q;
  logic               neg_q;
  phase_e             phase_q;

  logic [15:0]        us_q;
  logic signed [31:0] fb_q;
  logic [27:0]        dv_q, stp_q;
  logic [46:0]        num_q;
  logic [27:0]        qe_q;
  logic [63:0]        sa_q, diff_q;
  logic [65:0]        prod_q, acc_q;
  logic [30:0]        brake_q;
  logic               out_valid_q;
  out_res_t           out_q;

  logic [32:0] mul_a, mul_b;
  div_req_t    dreq;
  div_rsp_t    drsp;

  tmp_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign q_pop_o     = (state_q == S_FETCH) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_DV_MUL:  begin mul_a = {2'b0, accel_q};      mul_b = {17'b0, us_q}; end
      S_POS_MUL: begin mul_a = {1'b0, abs32(fb_q)};  mul_b = {17'b0, us_q}; end
      // quotient estimate, at most two below floor(x / 1e6)
      S_DV_EST, S_POS_EST: begin
        mul_a = {1'b0, prod_q[46:15]};
        mul_b = {5'b0, US_RECIP};
      end
      S_DV_BACK, S_POS_BACK: begin
        mul_a = {5'b0, prod_q[59:32]};
        mul_b = {1'b0, US_PER_S};
      end
      S_SA:      begin mul_a = {1'b0, abs32(spd_q)}; mul_b = {1'b0, abs32(spd_q)}; end
      S_SB:      begin mul_a = {1'b0, abs32(fin_q)}; mul_b = {1'b0, abs32(fin_q)}; end
      S_LO:      begin mul_a = {1'b0, diff_q[31:0]};  mul_b = recip_q; end
      S_HI:      begin mul_a = {1'b0, diff_q[63:32]}; mul_b = recip_q; end
      default: ;
    endcase
  end

  // remainder check on the estimate: add 0, 1 or 2
  logic [47:0] fix_rem;
  logic [27:0] fix_q;
  always_comb begin
    fix_rem = {1'b0, num_q} - prod_q[47:0];
    if (fix_rem >= {15'b0, US_PER_S, 1'b0})  fix_q = qe_q + 28'd2;
    else if (fix_rem >= {16'b0, US_PER_S})   fix_q = qe_q + 28'd1;
    else                                     fix_q = qe_q;
  end

  // start decode
  logic               st_neg, st_short;
  logic [30:0]        st_dist, st_top, st_fin;
  logic signed [31:0] st_fin_raw;
  always_comb begin
    st_neg     = cfg_dist_q[31];
    st_dist    = mag_sat(cfg_dist_q);
    st_short   = ({1'b0, st_dist} < FX_ONE);
    st_fin_raw = (cfg_end_q > cfg_peak_q) ? cfg_peak_q : cfg_end_q;
    st_top     = mag_sat(cfg_peak_q);
    st_fin     = mag_sat(st_fin_raw);
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    case (state_q)
      S_FETCH: begin
        if (q_valid_i && q_item_i.op == OP_START && !st_short &&
            {1'b0, cfg_accel_q} >= FX_ONE) begin
          dreq.start    = 1'b1;
          dreq.dividend = {1'b1, {(DIV_W-1){1'b0}}};
          dreq.divisor  = {1'b0, cfg_accel_q};
        end
      end
      default: ;
    endcase
  end

  // braking distance from the two partial products
  logic [97:0] brk_sum;
  logic [48:0] brk_res;
  always_comb begin
    brk_sum = {32'b0, acc_q} + {prod_q, 32'b0};
    brk_res = brk_sum[97:49];
  end

  // end-of-tick update
  logic signed [33:0] rem_s, goal_s, sn_s, ramp_s, stp_s, pos_s;
  logic signed [31:0] goal_eff, pos_new;
  logic               brake_hit, fin_hit;
  phase_e             ph_new;
  always_comb begin
    rem_s     = $signed({3'b0, goal_dist_q}) - $signed({2'b0, abs32(pos_q)});
    brake_hit = (phase_q == PH_ACCEL) && (rem_s < $signed({3'b0, brake_q}));
    goal_eff  = brake_hit ? fin_q : goal_q;
    ph_new    = brake_hit ? PH_BRAKE : phase_q;
    goal_s    = {{2{goal_eff[31]}}, goal_eff};
    sn_s      = {{2{spd_q[31]}}, spd_q};
    ramp_s    = sn_s;
    if (sn_s < goal_s) begin
      ramp_s = sn_s + $signed({6'b0, dv_q});
      if (ramp_s > goal_s) ramp_s = goal_s;
    end else if (sn_s > goal_s) begin
      ramp_s = sn_s - $signed({6'b0, dv_q});
      if (ramp_s < goal_s) ramp_s = goal_s;
    end
    stp_s = fb_q[31] ? -$signed({6'b0, stp_q}) : $signed({6'b0, stp_q});
    pos_s = $signed({{2{pos_q[31]}}, pos_q}) + stp_s;
    if (pos_s > $signed(34'sh0_7FFF_FFFF))      pos_new = 32'sh7FFF_FFFF;
    else if (pos_s < $signed(34'sh3_8000_0000)) pos_new = 32'sh8000_0000;
    else                                        pos_new = pos_s[31:0];
    fin_hit = (ph_new != PH_DONE) && (rem_s < $signed(FX_EIGHTH));
  end

  logic emit;
  assign emit = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FETCH;
      cfg_dist_q  <= '0;
      cfg_peak_q  <= '0;
      cfg_end_q   <= '0;
      cfg_accel_q <= '0;
      pos_q       <= '0;
      spd_q       <= '0;
      goal_q      <= '0;
      fin_q       <= '0;
      goal_dist_q <= '0;
      accel_q     <= '0;
      recip_q     <= '0;
      neg_q       <= 1'b0;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      us_q        <= '0;
      fb_q        <= '0;
      dv_q        <= '0;
      stp_q       <= '0;
      num_q       <= '0;
      qe_q        <= '0;
      sa_q        <= '0;
      diff_q      <= '0;
      acc_q       <= '0;
      brake_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DISTANCE: cfg_dist_q  <= cfg_data_i;
          CFG_PEAK:     cfg_peak_q  <= cfg_data_i;
          CFG_END:      cfg_end_q   <= cfg_data_i;
          CFG_ACCEL:    cfg_accel_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && !emit) out_valid_q <= 1'b0;

      unique case (state_q)
        S_FETCH: begin
          if (q_valid_i) begin
            us_q <= q_item_i.us;
            fb_q <= q_item_i.fb;
            unique case (q_item_i.op)
              OP_TICK: state_q <= (phase_q == PH_IDLE) ? S_EMIT : S_DV_MUL;
              OP_START: begin
                neg_q <= st_neg;
                if (st_short) begin
                  phase_q <= PH_DONE;
                  state_q <= S_EMIT;
                end else begin
                  pos_q       <= '0;
                  goal_dist_q <= st_dist;
                  goal_q      <= st_neg ? -$signed({1'b0, st_top}) : $signed({1'b0, st_top});
                  fin_q       <= st_neg ? -$signed({1'b0, st_fin}) : $signed({1'b0, st_fin});
                  accel_q     <= cfg_accel_q;
                  phase_q     <= PH_ACCEL;
                  if ({1'b0, cfg_accel_q} >= FX_ONE) begin
                    state_q <= S_RCP_WAIT;
                  end else begin
                    recip_q <= {1'b1, 32'b0};
                    state_q <= S_EMIT;
                  end
                end
              end
              OP_STOP: begin
                goal_q  <= '0;
                spd_q   <= '0;
                phase_q <= PH_DONE;
                state_q <= S_EMIT;
              end
              OP_RESET: begin
                pos_q   <= '0;
                spd_q   <= '0;
                goal_q  <= '0;
                phase_q <= PH_IDLE;
                state_q <= S_EMIT;
              end
              default: ;
            endcase
          end
        end
        S_RCP_WAIT: if (drsp.done) begin
          recip_q <= drsp.quotient[32:0];
          state_q <= S_EMIT;
        end
        S_DV_MUL: state_q <= S_DV_EST;
        S_DV_EST: begin
          num_q   <= prod_q[46:0];
          state_q <= S_DV_BACK;
        end
        S_DV_BACK: begin
          qe_q    <= prod_q[59:32];
          state_q <= S_DV_FIX;
        end
        S_DV_FIX: begin
          dv_q    <= fix_q;
          state_q <= S_POS_MUL;
        end
        S_POS_MUL: state_q <= S_POS_EST;
        S_POS_EST: begin
          num_q   <= prod_q[46:0];
          state_q <= S_POS_BACK;
        end
        S_POS_BACK: begin
          qe_q    <= prod_q[59:32];
          state_q <= S_POS_FIX;
        end
        S_POS_FIX: begin
          stp_q   <= fix_q;
          state_q <= S_SA;
        end
        S_SA: state_q <= S_SB;
        S_SB: begin
          sa_q    <= prod_q[63:0];
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          diff_q  <= (sa_q > prod_q[63:0]) ? sa_q - prod_q[63:0] : prod_q[63:0] - sa_q;
          state_q <= S_LO;
        end
        S_LO: state_q <= S_HI;
        S_HI: begin
          acc_q   <= prod_q;
          state_q <= S_BRK;
        end
        S_BRK: begin
          brake_q <= (|brk_res[48:31]) ? 31'h7FFF_FFFF : brk_res[30:0];
          state_q <= S_UPD;
        end
        S_UPD: begin
          spd_q   <= ramp_s[31:0];
          pos_q   <= pos_new;
          goal_q  <= (brake_hit || fin_hit) ? fin_q : goal_q;
          phase_q <= fin_hit ? PH_DONE : ph_new;
          state_q <= S_EMIT;
        end
        S_EMIT: if (emit) begin
          out_valid_q         <= 1'b1;
          out_q.command_speed <= spd_q;
          out_q.travelled     <= pos_q;
          out_q.phase         <= phase_q;
          out_q.done_res      <= (phase_q == PH_DONE);
          state_q             <= S_FETCH;
        end
        default: state_q <= S_FETCH;
      endcase
    end
  end

endmodule

>>> bench/tb.sv
// Self-checking bench for trapezoid_motion_profile: random tick/start/stop/reset requests,
// predicted per request and checked field by field. Depends on tmp_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import tmp_pkg::*;

  localparam int WATCHDOG = 8000;
  localparam int SETTLE   = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_res_t    out_res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  trapezoid_motion_profile dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // request queue, expected results, bookkeeping
  in_item_t  pending_q[$];
  out_res_t  expected_q[$];
  int        errors = 0, n_req = 0, n_res = 0, n_start = 0, n_done = 0;
  int        idle_cycles = 0;
  bit        req_taken = 0, cfg_taken = 0, quiet = 0, long_req = 0;

  // shadow configuration and motion state
  longint    cfg_dist, cfg_peak, cfg_end, cfg_accel;
  longint    pos_acc, spd_now, spd_goal, spd_final, goal_dist;
  longint    acc_held, acc_recip;
  bit        dir_neg;
  phase_e    cur_phase = PH_IDLE;

  function automatic longint mag_clamp(longint v);
    longint m;
    m = v < 0 ? -v : v;
    return m > 64'sd2147483647 ? 64'sd2147483647 : m;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint brake_dist();
    bit [63:0] a, b, sa, sb, diff, dh, dl, hi, lo, res;
    a = spd_now < 0 ? -spd_now : spd_now;
    b = spd_final < 0 ? -spd_final : spd_final;
    sa = a * a;
    sb = b * b;
    diff = sa > sb ? sa - sb : sb - sa;
    dh = diff >> 32;
    dl = diff & 64'hFFFF_FFFF;
    hi = dh * acc_recip;
    lo = dl * acc_recip;
    res = (hi >> 17) + ((((hi & 64'h1FFFF) << 15) + (lo >> 17)) >> 32);
    if (res > 64'd2147483647) res = 64'd2147483647;
    return longint'(res);
  endfunction

  task automatic model_start();
    longint mv_len, fin, top;
    mv_len = mag_clamp(cfg_dist);
    dir_neg = cfg_dist < 0;
    if (mv_len < 65536) begin
      cur_phase = PH_DONE;
      return;
    end
    fin = cfg_end > cfg_peak ? cfg_peak : cfg_end;
    pos_acc = 0;
    goal_dist = mv_len;
    top = mag_clamp(cfg_peak);
    fin = mag_clamp(fin);
    spd_goal = dir_neg ? -top : top;
    spd_final = dir_neg ? -fin : fin;
    acc_held = cfg_accel;
    acc_recip = acc_held >= 65536 ? (64'sd1 <<< 48) / acc_held : 64'sd1 <<< 32;
    cur_phase = PH_ACCEL;
  endtask

  task automatic model_tick(longint us, longint fb);
    longint dv, remaining;
    if (cur_phase == PH_IDLE) return;
    dv = (acc_held * us) / 1000000;
    remaining = goal_dist - (pos_acc < 0 ? -pos_acc : pos_acc);
    if (cur_phase == PH_ACCEL && remaining < brake_dist()) begin
      cur_phase = PH_BRAKE;
      spd_goal = spd_final;
    end
    if (spd_now < spd_goal) begin
      spd_now += dv;
      if (spd_now > spd_goal) spd_now = spd_goal;
    end else if (spd_now > spd_goal) begin
      spd_now -= dv;
      if (spd_now < spd_goal) spd_now = spd_goal;
    end
    pos_acc = clamp32(pos_acc + (fb * us) / 1000000);
    if (cur_phase != PH_DONE && remaining < 8192) begin
      cur_phase = PH_DONE;
      spd_goal = spd_final;
    end
  endtask

  task automatic predict_profile(in_item_t it);
    out_res_t r;
    case (op_e'(it.op))
      OP_TICK:  model_tick(longint'(it.tick_time_us), longint'(it.measured_speed));
      OP_START: begin
        model_start();
        n_start++;
      end
      OP_STOP: begin
        spd_goal = 0;
        spd_now = 0;
        cur_phase = PH_DONE;
      end
      default: begin
        pos_acc = 0;
        spd_now = 0;
        spd_goal = 0;
        cur_phase = PH_IDLE;
      end
    endcase
    r.command_speed = 32'(spd_now);
    r.travelled = 32'(pos_acc);
    r.phase = cur_phase;
    r.done_res = cur_phase == PH_DONE;
    expected_q.push_back(r);
  endtask

  // predictor, monitor and watchdog at the rising edge
  always @(posedge clk_i) begin
    out_res_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DISTANCE: cfg_dist = longint'(signed'(cfg_data_i));
          CFG_PEAK:     cfg_peak = longint'(signed'(cfg_data_i));
          CFG_END:      cfg_end = longint'(signed'(cfg_data_i));
          default:      cfg_accel = longint'(cfg_data_i[30:0]);
        endcase
        cfg_taken = 1;
      end
      if (in_valid_i && !in_stall_o) begin
        predict_profile(in_item_i);
        req_taken = 1;
        n_req++;
      end
      if (out_valid_o && !out_stall_i) begin
        n_res++;
        if (out_res_o.done_res) n_done++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, out_res_o);
        end else begin
          e = expected_q.pop_front();
          if (out_res_o.command_speed !== e.command_speed) begin
            errors++;
            $display("%0t: command_speed exp %0d got %0d", $time, e.command_speed,
                     out_res_o.command_speed);
          end
          if (out_res_o.travelled !== e.travelled) begin
            errors++;
            $display("%0t: travelled exp %0d got %0d", $time, e.travelled,
                     out_res_o.travelled);
          end
          if (out_res_o.phase !== e.phase) begin
            errors++;
            $display("%0t: phase exp %0d got %0d", $time, e.phase, out_res_o.phase);
          end
          if (out_res_o.done_res !== e.done_res) begin
            errors++;
            $display("%0t: done_res exp %0d got %0d", $time, e.done_res,
                     out_res_o.done_res);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o) ||
          (pending_q.size() == 0 && expected_q.size() == 0 && !in_valid_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, expected_q.size());
        $display("trapezoid_motion_profile regression: fail");
        $finish;
      end
    end
  end

  // request driver
  int send_gap = 0;
  always @(negedge clk_i) begin
    logic     nxt_valid;
    in_item_t nxt_item;
    nxt_valid = in_valid_i;
    nxt_item = in_item_i;
    if (!in_valid_i || req_taken) begin
      req_taken = 0;
      nxt_valid = 1'b0;
      if (send_gap > 0) send_gap--;
      else if (pending_q.size() > 0) begin
        nxt_item = pending_q.pop_front();
        nxt_valid = 1'b1;
        send_gap = quiet ? 0 : $urandom_range(0, 17);
      end
    end
    in_valid_i <= nxt_valid;
    in_item_i <= nxt_item;
  end

  // result receiver stall
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (long_req) begin
      long_req = 0;
      stall_left = 500;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (out_valid_o && !quiet) stall_left = $urandom_range(0, 17);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_taken = 0;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_move(logic [31:0] d, logic [31:0] p, logic [31:0] f, logic [31:0] a);
    write_reg(CFG_DISTANCE, d);
    write_reg(CFG_PEAK, p);
    write_reg(CFG_END, f);
    write_reg(CFG_ACCEL, {1'b0, a[30:0]});
  endtask

  task automatic push(op_e op, logic [15:0] us, logic [31:0] fb);
    in_item_t it;
    it.op = op;
    it.tick_time_us = us;
    it.measured_speed = fb;
    pending_q.push_back(it);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid_i && expected_q.size() == 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [31:0] fx_signed(int unsigned mag_max);
    logic [31:0] m;
    m = $urandom_range(0, mag_max);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  initial begin
    logic [31:0] peak, fb;
    int n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: 10.0 long, peak 2.0, end 0.5, accel 1.0
    set_move(32'h000A_0000, 32'h0002_0000, 32'h0000_8000, 32'h0001_0000);
    push(OP_TICK, 16'd1000, 32'h0001_0000);           // idle tick
    push(OP_START, 16'd0, 32'd0);
    push(OP_TICK, 16'hFFFF, 32'h7FFF_FFFF);
    push(OP_TICK, 16'd0, 32'h8000_0000);
    push(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    push(OP_STOP, 16'hFFFF, 32'd0);
    push(OP_TICK, 16'd50000, 32'h0002_0000);          // tick after finish
    push(OP_RESET, 16'd0, 32'h7FFF_FFFF);
    push(OP_TICK, 16'd100, 32'd5);
    drain();
    // extremes: most negative distance and peak speed, largest end speed, full accel
    set_move(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push(OP_START, 16'd0, 32'd0);
    for (int i = 0; i < 6; i++) push(OP_TICK, 16'hFFFF, 32'h8000_0000);
    for (int i = 0; i < 6; i++) push(OP_TICK, 16'hFFFF, 32'h7FFF_FFFF);
    drain();
    // short move, and accel below 1.0
    set_move(32'hFFFF_8000, 32'h0001_0000, 32'h0000_0000, 32'h0000_4000);
    push(OP_START, 16'd0, 32'd0);
    push(OP_TICK, 16'd1000, 32'h0000_1000);
    drain();
    write_reg(CFG_DISTANCE, 32'h0003_0000);
    push(OP_START, 16'd0, 32'd0);
    push(OP_TICK, 16'd40000, 32'h0001_0000);
    drain();

    // random moves
    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph % 4 == 3);
      if (ph == 5) set_move($urandom, $urandom, $urandom, $urandom);
      else set_move(fx_signed(200 << 16), fx_signed(60 << 16), fx_signed(60 << 16),
                    $urandom_range(0, 40 << 16));
      if (ph == 6) long_req = 1;
      peak = fx_signed(60 << 16);
      n = 0;
      while (n < 45) begin
        case ($urandom_range(0, 19))
          0: push(OP_START, 16'($urandom), $urandom);
          1: push(OP_STOP, 16'($urandom), $urandom);
          2: push(OP_RESET, 16'($urandom), $urandom);
          3: push(op_e'($urandom_range(0, 3)), 16'($urandom), $urandom);
          default: begin
            if (n == 0) push(OP_START, 16'($urandom), $urandom);
            fb = peak + fx_signed(4 << 16);
            push(OP_TICK, 16'($urandom_range(1, 30000)), fb);
          end
        endcase
        n++;
      end
      drain();
    end

    $display("covered %0d requests, %0d results, %0d starts, %0d finished-phase results",
             n_req, n_res, n_start, n_done);
    if (errors == 0) $display("trapezoid_motion_profile regression: pass");
    else $display("trapezoid_motion_profile regression: fail");
    $finish;
  end

endmodule
